// ===== rtl/quadratic_bspline_point_eval_assert.svh =====
// Assertion macros shared by the spline evaluator modules.
// Uses the module's clock and reset names; no other dependencies.
`ifndef QUADRATIC_BSPLINE_POINT_EVAL_ASSERT_SVH
`define QUADRATIC_BSPLINE_POINT_EVAL_ASSERT_SVH
`ifndef SYNTH
`define QBSP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("spline evaluator assertion failed");
`define QBSP_ASSERT_NORST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("spline evaluator reset assertion failed");
`else
`define QBSP_ASSERT(label, prop)
`define QBSP_ASSERT_NORST(label, prop)
`endif
`endif

// ===== rtl/qbsp_pkg.sv =====
// Types and constants for the quadratic B-spline point evaluator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package qbsp_pkg;

   localparam int NUM_POINTS   = 5;
   localparam int COORD_W      = 12;
   localparam int IDX_W        = 3;
   localparam int U_W          = 10;
   localparam int FRAC_W       = 8;
   localparam int SPAN_W       = 2;
   localparam int WEIGHT_W     = 18;
   localparam int WIDE_W       = 20;
   localparam int PROD_W       = WEIGHT_W + COORD_W;
   localparam int WEIGHT_SHIFT = 17;
   localparam int TAPS         = 3;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   localparam logic [SPAN_W-1:0] SPAN_FIRST = 2'd0;
   localparam logic [SPAN_W-1:0] SPAN_MID   = 2'd1;
   localparam logic [SPAN_W-1:0] SPAN_LAST  = 2'd2;
   localparam logic [SPAN_W-1:0] SPAN_NONE  = 2'd3;

   localparam logic [WIDE_W-1:0] FULL_WEIGHT = 20'd131072;

   typedef logic [COORD_W-1:0]  coord_type;
   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef logic [PROD_W-1:0]   prod_type;

   // Stage 1: decoded parameter and a snapshot of the whole point store.
   typedef struct packed {
      logic [SPAN_W-1:0]            span;
      logic [FRAC_W-1:0]            f;
      logic [FRAC_W:0]              g;
      coord_type [NUM_POINTS-1:0]   px;
      coord_type [NUM_POINTS-1:0]   py;
   } s1_type;

   // Stage 2: squares and the three points of the active span.
   typedef struct packed {
      logic [SPAN_W-1:0]      span;
      logic [FRAC_W-1:0]      f;
      logic [FRAC_W:0]        g;
      logic [2*FRAC_W-1:0]    f2;
      logic [2*FRAC_W:0]      g2;
      coord_type [TAPS-1:0]   px;
      coord_type [TAPS-1:0]   py;
   } s2_type;

   // Stage 3: basis weights of the active span.
   typedef struct packed {
      weight_type [TAPS-1:0]  w;
      coord_type [TAPS-1:0]   px;
      coord_type [TAPS-1:0]   py;
   } s3_type;

   // Stage 4: weighted coordinates.
   typedef struct packed {
      prod_type [TAPS-1:0]    prod_x;
      prod_type [TAPS-1:0]    prod_y;
   } s4_type;

endpackage

// ===== rtl/qbsp_store.sv =====
// Control point store and first pipeline stage of the spline evaluator.
// Depends on qbsp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "quadratic_bspline_point_eval_assert.svh"

module qbsp_store (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  logic [2:0]                req_point_index,
   input  logic [11:0]               req_coord_x,
   input  logic [11:0]               req_coord_y,
   input  logic [9:0]                req_param_u,
   output logic                      s1_valid,
   input  logic                      s1_ready_dn,
   output qbsp_pkg::s1_type          s1_data
);
   import qbsp_pkg::*;

   coord_type point_x_ff [NUM_POINTS];
   coord_type point_y_ff [NUM_POINTS];

   logic    s1_valid_ff;
   logic    s1_valid_in;
   s1_type  s1_data_ff;
   s1_type  s1_data_in;
   logic    s1_ready;
   logic    accept;
   logic    load_en;

   assign s1_ready  = !s1_valid_ff || s1_ready_dn;
   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;
   assign load_en   = accept && (req_kind == KIND_LOAD)
                      && ({1'b0, req_point_index} < 4'(NUM_POINTS));

   // Loads write the store at acceptance, so an evaluate item that follows
   // in the next cycle already sees the new point in its snapshot.
   always_comb begin
      s1_data_in.span = req_param_u[U_W-1:FRAC_W];
      s1_data_in.f    = req_param_u[FRAC_W-1:0];
      s1_data_in.g    = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, req_param_u[FRAC_W-1:0]};
      for (int i = 0; i < NUM_POINTS; i++) begin
         s1_data_in.px[i] = point_x_ff[i];
         s1_data_in.py[i] = point_y_ff[i];
      end
      s1_valid_in = s1_ready ? (accept && (req_kind == KIND_EVAL)) : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_POINTS; i++) begin
            point_x_ff[i] <= '0;
            point_y_ff[i] <= '0;
         end
         s1_valid_ff <= 1'b0;
      end else begin
         if (load_en) begin
            point_x_ff[req_point_index] <= req_coord_x;
            point_y_ff[req_point_index] <= req_coord_y;
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= s1_data_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_data_ff;

   `QBSP_ASSERT(a_load_x, load_en |=> point_x_ff[$past(req_point_index)] == $past(req_coord_x))
   `QBSP_ASSERT(a_load_y, load_en |=> point_y_ff[$past(req_point_index)] == $past(req_coord_y))
   `QBSP_ASSERT(a_stall_full, req_stall |-> s1_valid_ff)

endmodule

// ===== rtl/qbsp_weight.sv =====
// Basis weight stages of the spline evaluator: squares, then weights.
// Depends on qbsp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "quadratic_bspline_point_eval_assert.svh"

module qbsp_weight (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      s1_valid,
   output logic                      s1_ready,
   input  qbsp_pkg::s1_type          s1_data,
   output logic                      s3_valid,
   input  logic                      s3_ready_dn,
   output qbsp_pkg::s3_type          s3_data
);
   import qbsp_pkg::*;

   logic    s2_valid_ff;
   logic    s2_valid_in;
   s2_type  s2_data_ff;
   s2_type  s2_data_in;
   logic    s2_ready;
   logic    s3_valid_ff;
   logic    s3_valid_in;
   s3_type  s3_data_ff;
   s3_type  s3_data_in;
   logic    s3_ready;

   logic [WIDE_W-1:0] f2e;
   logic [WIDE_W-1:0] g2e;
   logic [WIDE_W-1:0] f10;
   logic [WIDE_W-1:0] g10;
   logic [WIDE_W-1:0] wide [TAPS];
   logic [WIDE_W-1:0] w_sum;

   assign s3_ready = !s3_valid_ff || s3_ready_dn;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = s2_ready;

   // Stage 2: squares of f and g, and the three points of the span.
   always_comb begin
      s2_data_in.span = s1_data.span;
      s2_data_in.f    = s1_data.f;
      s2_data_in.g    = s1_data.g;
      s2_data_in.f2   = s1_data.f * s1_data.f;
      s2_data_in.g2   = s1_data.g * s1_data.g;
      for (int k = 0; k < TAPS; k++) begin
         case (s1_data.span)
            SPAN_FIRST: begin
               s2_data_in.px[k] = s1_data.px[k];
               s2_data_in.py[k] = s1_data.py[k];
            end
            SPAN_MID: begin
               s2_data_in.px[k] = s1_data.px[k+1];
               s2_data_in.py[k] = s1_data.py[k+1];
            end
            default: begin
               s2_data_in.px[k] = s1_data.px[k+2];
               s2_data_in.py[k] = s1_data.py[k+2];
            end
         endcase
      end
      s2_valid_in = s2_ready ? s1_valid : s2_valid_ff;
   end

   // Stage 3: weights. Intermediates are kept wider than a weight because
   // 1024*g reaches 2^18 at the start of the last span.
   always_comb begin
      f2e = WIDE_W'(s2_data_ff.f2);
      g2e = WIDE_W'(s2_data_ff.g2);
      f10 = WIDE_W'(s2_data_ff.f) << 10;
      g10 = WIDE_W'(s2_data_ff.g) << 10;
      case (s2_data_ff.span)
         SPAN_FIRST: begin
            wide[0] = g2e << 1;
            wide[1] = f10 - (f2e + (f2e << 1));
            wide[2] = f2e;
         end
         SPAN_MID: begin
            wide[0] = g2e;
            wide[1] = FULL_WEIGHT - g2e - f2e;
            wide[2] = f2e;
         end
         SPAN_LAST: begin
            wide[0] = g2e;
            wide[1] = g10 - (g2e + (g2e << 1));
            wide[2] = f2e << 1;
         end
         default: begin
            wide[0] = '0;
            wide[1] = '0;
            wide[2] = '0;
         end
      endcase
      for (int k = 0; k < TAPS; k++) begin
         s3_data_in.w[k] = wide[k][WEIGHT_W-1:0];
      end
      s3_data_in.px = s2_data_ff.px;
      s3_data_in.py = s2_data_ff.py;
      s3_valid_in   = s3_ready ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid) begin
         s2_data_ff <= s2_data_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign s3_valid = s3_valid_ff;
   assign s3_data  = s3_data_ff;

   assign w_sum = WIDE_W'(s3_data_ff.w[0]) + WIDE_W'(s3_data_ff.w[1])
                  + WIDE_W'(s3_data_ff.w[2]);

   // Inside the domain the weights form a partition of unity.
   `QBSP_ASSERT(a_weight_sum, s3_valid_ff |-> (w_sum == FULL_WEIGHT) || (w_sum == '0))

endmodule

// ===== rtl/qbsp_mac.sv =====
// Multiply and accumulate stages of the spline evaluator, with the
// output register. Depends on qbsp_pkg.
`timescale 1ns / 1ps

module qbsp_mac (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      s3_valid,
   output logic                      s3_ready,
   input  qbsp_pkg::s3_type          s3_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [11:0]               rsp_pixel_x,
   output logic [11:0]               rsp_pixel_y
);
   import qbsp_pkg::*;

   logic       s4_valid_ff;
   logic       s4_valid_in;
   s4_type     s4_data_ff;
   s4_type     s4_data_in;
   logic       s4_ready;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       rsp_ready;
   coord_type  pixel_x_ff;
   coord_type  pixel_y_ff;
   prod_type   sum_x;
   prod_type   sum_y;

   assign rsp_ready = !rsp_valid_ff || !rsp_stall;
   assign s4_ready  = !s4_valid_ff || rsp_ready;
   assign s3_ready  = s4_ready;

   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         s4_data_in.prod_x[k] = PROD_W'(s3_data.w[k]) * PROD_W'(s3_data.px[k]);
         s4_data_in.prod_y[k] = PROD_W'(s3_data.w[k]) * PROD_W'(s3_data.py[k]);
      end
      s4_valid_in = s4_ready ? s3_valid : s4_valid_ff;
   end

   // The weights sum to 2^17, so the sums cannot overflow and the shift
   // leaves a value no larger than the largest coordinate.
   assign sum_x = s4_data_ff.prod_x[0] + s4_data_ff.prod_x[1] + s4_data_ff.prod_x[2];
   assign sum_y = s4_data_ff.prod_y[0] + s4_data_ff.prod_y[1] + s4_data_ff.prod_y[2];
   assign rsp_valid_in = rsp_ready ? s4_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff  <= s4_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid) begin
         s4_data_ff <= s4_data_in;
      end
      if (rsp_ready && s4_valid_ff) begin
         pixel_x_ff <= sum_x[WEIGHT_SHIFT+COORD_W-1:WEIGHT_SHIFT];
         pixel_y_ff <= sum_y[WEIGHT_SHIFT+COORD_W-1:WEIGHT_SHIFT];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pixel_x = pixel_x_ff;
   assign rsp_pixel_y = pixel_y_ff;

endmodule

// ===== rtl/quadratic_bspline_point_eval.sv =====
// An evaluate item's result passes the stage registers s1 to s4 and the output register
// before it shows on rsp_valid, and is taken from there when rsp_stall is low.
// Throughput: one item per cycle unless rsp_stall backs up the pipeline; each of the five
// pipeline stages holds one item and moves on whenever the stage after it has room.
// Load items update the point store in their acceptance cycle and give no result.
// Reset clears the point store to zero and empties the pipeline.
`timescale 1ns / 1ps
`include "quadratic_bspline_point_eval_assert.svh"

module quadratic_bspline_point_eval (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_kind,
   input  logic [2:0]   req_point_index,
   input  logic [11:0]  req_coord_x,
   input  logic [11:0]  req_coord_y,
   input  logic [9:0]   req_param_u,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [11:0]  rsp_pixel_x,
   output logic [11:0]  rsp_pixel_y
);
   import qbsp_pkg::*;

   logic    s1_valid;
   logic    s1_ready;
   s1_type  s1_data;
   logic    s3_valid;
   logic    s3_ready;
   s3_type  s3_data;

   qbsp_store u_store (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_point_index (req_point_index),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_param_u     (req_param_u),
      .s1_valid        (s1_valid),
      .s1_ready_dn     (s1_ready),
      .s1_data         (s1_data)
   );

   qbsp_weight u_weight (
      .clock       (clock),
      .reset       (reset),
      .s1_valid    (s1_valid),
      .s1_ready    (s1_ready),
      .s1_data     (s1_data),
      .s3_valid    (s3_valid),
      .s3_ready_dn (s3_ready),
      .s3_data     (s3_data)
   );

   qbsp_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .s3_valid    (s3_valid),
      .s3_ready    (s3_ready),
      .s3_data     (s3_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y)
   );

   `QBSP_ASSERT_NORST(a_reset_empty, reset |=> !rsp_valid)

endmodule
